// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the sorter sequencer (isort_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held.
`define ISORT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ISORT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/isort_pkg.sv =====
`timescale 1ns / 1ps

package isort_pkg;

  localparam int VALUE_W   = 32;
  localparam int DEPTH_DEF = 16;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } isort_state_t;

  // Sequencer strobes for the whole chain.
  typedef struct packed {
    logic ins;   // insert the incoming value
    logic pop;   // shift every entry one cell toward the output
  } isort_seq_t;

  // Per-cell control.
  typedef struct packed {
    logic ins;
    logic pop;
    logic occ;   // cell holds a valid entry
    logic head;  // first empty cell
  } isort_cell_ctrl_t;

endpackage

// ===== rtl/core/isort_if.sv =====
`timescale 1ns / 1ps

interface isort_in_if;
  import isort_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  import isort_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      final_res;
  logic                      dropped;

  modport source (output valid, output sorted_value, output final_res, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input dropped,
                  output ready);
endinterface

// ===== rtl/core/insertion_sorter_top.sv =====
`timescale 1ns / 1ps

// Stable ascending insertion sorter for signed 32-bit values, built as a chain of
// DEPTH cells. While a run is being collected one value is accepted per clock:
// every cell compares the new value against its entry in the same cycle, and the
// cells at and above the insert point shift one place up, so insertion never
// stalls. A value that arrives on a full chain is discarded and every result of
// that run carries dropped = 1. After the value marked last has been taken, the
// chain drains out of cell 0 one entry per output transaction, smallest first;
// the input is not ready until the whole run has drained. final_res marks the
// largest entry, after which the store is empty and the next run can start.
// Results come straight from the cell 0 register and the sequencer state.

module insertion_sorter_top #(
  parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  isort_in_if.sink           in_if,
  isort_out_if.source        out_if
);
  import isort_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  isort_seq_t                seq;
  logic [FILL_W-1:0]         fill;
  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic                      cell_less [DEPTH];

  // Sequencer: run state, fill count and overflow flag.
  isort_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_last   (in_if.last),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .final_res (out_if.final_res),
    .dropped   (out_if.dropped),
    .seq       (seq),
    .fill      (fill)
  );

  // Cell chain. Cell k is occupied when k is below the fill count; the cell at
  // the fill count is the free slot a largest-so-far value lands in.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    isort_cell_ctrl_t          ctl;
    logic                      less_prev;
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    assign ctl.ins  = seq.ins;
    assign ctl.pop  = seq.pop;
    assign ctl.occ  = (FILL_W'(k) < fill);
    assign ctl.head = (FILL_W'(k) == fill);

    if (k == 0) begin : g_first
      // Nothing below cell 0 moves up into it.
      assign less_prev  = 1'b0;
      assign left_value = in_if.value;
    end else begin : g_mid
      assign less_prev  = cell_less[k-1];
      assign left_value = cell_val[k-1];
    end

    if (k == DEPTH - 1) begin : g_top
      // Past the top entry there is nothing to drain in; content is don't-care.
      assign right_value = cell_val[k];
    end else begin : g_inner
      assign right_value = cell_val[k+1];
    end

    isort_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .ins_value   (in_if.value),
      .less_prev   (less_prev),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_val[k]),
      .less        (cell_less[k])
    );
  end

  // Smallest entry always sits in cell 0.
  assign out_if.sorted_value = cell_val[0];

endmodule

// ===== rtl/core/isort_cell.sv =====
`timescale 1ns / 1ps

module isort_cell (
  input  logic                                clk,
  input  isort_pkg::isort_cell_ctrl_t         ctl,
  input  logic signed [isort_pkg::VALUE_W-1:0] ins_value,
  input  logic                                less_prev,
  input  logic signed [isort_pkg::VALUE_W-1:0] left_value,
  input  logic signed [isort_pkg::VALUE_W-1:0] right_value,
  output logic signed [isort_pkg::VALUE_W-1:0] value,
  output logic                                less
);
  import isort_pkg::*;

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;

  // Strictly smaller only: equal values stay in arrival order.
  assign less = ctl.occ && (ins_value < value_r);

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (less_prev) begin
        value_nxt = left_value;
      end else if (less || ctl.head) begin
        value_nxt = ins_value;
      end
    end else if (ctl.pop) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== rtl/core/isort_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isort_ctrl #(
  parameter  int DEPTH  = isort_pkg::DEPTH_DEF,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  final_res,
  output logic                  dropped,
  output isort_pkg::isort_seq_t seq,
  output logic [FILL_W-1:0]     fill
);
  import isort_pkg::*;

  isort_state_t      state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              acc;
  logic              full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign full = (fill_r == FILL_W'(DEPTH));
  assign acc  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    seq       = '0;
    unique case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            seq.ins  = 1'b1;
            fill_nxt = fill_r + 1'b1;
          end
          if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          seq.pop  = 1'b1;
          fill_nxt = fill_r - 1'b1;
          if (fill_r == FILL_W'(1)) begin
            state_nxt = ST_FILL;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  assign final_res = (fill_r == FILL_W'(1));
  assign dropped   = ovf_r;
  assign fill      = fill_r;

  `ISORT_NEVER(a_emit_nonempty, clk, rst_n, (state_r == ST_EMIT) && (fill_r == '0), "emit with empty store")
  `ISORT_ASSERT(a_last_starts_emit, clk, rst_n, acc && in_last |=> state_r == ST_EMIT, "last did not start emission")
  `ISORT_ASSERT(a_run_clears, clk, rst_n, out_valid && out_ready && final_res |=> (fill_r == '0) && !ovf_r, "run end did not clear state")
  `ISORT_NEVER(a_fill_bound, clk, rst_n, fill_r > FILL_W'(DEPTH), "fill count above depth")

endmodule
